[hw/rtl/rau_pkg.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared constants, command and status codes, and the status word of the
// iterative units.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int DEF_WIDTH     = 32;
	localparam int DEF_EXP_WIDTH = 16;
	localparam int FIELD_W       = 32;
	localparam int EXP_FIELD_W   = 16;
	localparam int DEN_W         = 31;
	localparam int CMD_W         = 3;
	localparam int ST_W          = 2;
	localparam int S_DATA_W      = 4 * FIELD_W + EXP_FIELD_W;
	localparam int M_DATA_W      = ((FIELD_W + DEN_W + 7) / 8) * 8;
	localparam int PAD_W         = M_DATA_W - FIELD_W - DEN_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_ABS = 3'd4,
		CMD_RED = 3'd5,
		CMD_POW = 3'd6
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK   = 2'd0,
		ST_DIV0 = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

[hw/rtl/rau_gcd.sv]
// ----------------------------------------------------------------------------
// Binary GCD unit
// Computes the greatest common divisor of two nonzero values, one shift or
// one subtract per cycle. The result is held until the next result is done.
// ----------------------------------------------------------------------------
module rau_gcd #(
	parameter int IW = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [IW-1:0]     x,
	input  logic [IW-1:0]     y,
	output logic [IW-1:0]     g,
	output rau_pkg::unit_sts_t sts
);
	import rau_pkg::*;

	localparam int KW = $clog2(IW);

	typedef enum logic [1:0] {G_IDLE, G_TWOS, G_XODD, G_LOOP} gstate_t;

	gstate_t       state_q;
	logic [IW-1:0] x_q;
	logic [IW-1:0] y_q;
	logic [IW-1:0] g_q;
	logic [KW-1:0] k_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				G_IDLE: begin
					if (start) begin
						x_q     <= x;
						y_q     <= y;
						k_q     <= '0;
						state_q <= G_TWOS;
					end
				end
				G_TWOS: begin
					if (!(x_q[0] | y_q[0])) begin
						x_q <= x_q >> 1;
						y_q <= y_q >> 1;
						k_q <= k_q + KW'(1);
					end else begin
						state_q <= G_XODD;
					end
				end
				G_XODD: begin
					if (!x_q[0]) begin
						x_q <= x_q >> 1;
					end else begin
						state_q <= G_LOOP;
					end
				end
				G_LOOP: begin
					if (y_q == '0) begin
						g_q     <= x_q << k_q;
						done_q  <= 1'b1;
						state_q <= G_IDLE;
					end else if (!y_q[0]) begin
						y_q <= y_q >> 1;
					end else if (x_q > y_q) begin
						x_q <= y_q;
						y_q <= x_q - y_q;
					end else begin
						y_q <= y_q - x_q;
					end
				end
				default: state_q <= G_IDLE;
			endcase
		end
	end

	assign g        = g_q;
	assign sts.busy = (state_q != G_IDLE);
	assign sts.done = done_q;

endmodule

[hw/rtl/rau_div.sv]
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div #(
	parameter int IW = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [IW-1:0]     dividend,
	input  logic [IW-1:0]     divisor,
	output logic [IW-1:0]     quo,
	output rau_pkg::unit_sts_t sts
);
	import rau_pkg::*;

	localparam int CW = $clog2(IW + 1);

	logic [IW-1:0] rem_q;
	logic [IW-1:0] quo_q;
	logic [IW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [IW+1:0] trial;

	assign trial = {1'b0, rem_q, quo_q[IW-1]} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				if (!trial[IW+1]) begin
					rem_q <= trial[IW-1:0];
					quo_q <= {quo_q[IW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[IW-2:0], quo_q[IW-1]};
					quo_q <= {quo_q[IW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				rem_q  <= '0;
				quo_q  <= dividend;
				dvs_q  <= divisor;
				cnt_q  <= CW'(IW);
				busy_q <= 1'b1;
			end
		end
	end

	assign quo      = quo_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

[hw/rtl/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Exact add, subtract, multiply, divide, absolute, reduce and power on
// fractions, with every result reduced by a binary GCD.
// ----------------------------------------------------------------------------
// A word on the slave channel carries the command in s_tuser and the two
// fractions and the exponent in s_tdata. One result word leaves on the
// master channel with the reduced fraction in m_tdata and the status in
// m_tuser. The block takes one word at a time: s_tready is high only while
// the sequencer is idle, and one shared multiplier, the GCD unit and the
// divider do all the work in turn.
// An error, a zero exponent or a zero numerator goes to the output without
// the GCD; other words run through the GCD loop and two divisions by the
// GCD, and a power then through a square-and-multiply loop on numerator
// and denominator in turn.
// Reset clears the sequencer and the output valid; a word in flight at reset
// is dropped.
// When the receiver stalls, a finished result waits in the output register;
// the sequencer takes the next word and holds in its output state until the waiting word is taken.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
	parameter int WIDTH     = rau_pkg::DEF_WIDTH,
	parameter int EXP_WIDTH = rau_pkg::DEF_EXP_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// a_num, a_den, b_num, b_den, power_exp
	input  logic [rau_pkg::S_DATA_W-1:0] s_tdata,
	// cmd
	input  logic [rau_pkg::CMD_W-1:0]    s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// res_num, res_den, zero padding
	output logic [rau_pkg::M_DATA_W-1:0] m_tdata,
	// status
	output logic [rau_pkg::ST_W-1:0]     m_tuser
);
	import rau_pkg::*;

	localparam int IW = 2 * WIDTH;
	localparam logic [IW-1:0] HALF = IW'(1) << (WIDTH - 1);
	localparam logic [IW-1:0] CAP  = HALF + IW'(1);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_MUL, S_ADD, S_FIN, S_GCD,
		S_DIVN, S_DIVD, S_POW, S_CHECK, S_OUT
	} state_t;

	state_t               state_q;
	cmd_t                 cmd_q;
	logic [WIDTH-1:0]     an_q, ad_q, bn_q, bd_q;
	logic                 an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
	logic [EXP_WIDTH-1:0] e_q;
	logic [IW-1:0]        num_q, den_q, aux_q;
	logic                 num_neg_q, den_neg_q, aux_neg_q;
	logic [1:0]           step_q;
	logic [WIDTH-1:0]     acc_q, base_q;
	logic [EXP_WIDTH-1:0] ebits_q;
	logic                 pow_sq_q, pow_den_q;
	logic [FIELD_W-1:0]   res_num_q;
	logic [DEN_W-1:0]     res_den_q;
	status_t              res_st_q;
	logic                 m_tvalid_q;
	logic [M_DATA_W-1:0]  m_data_q;
	logic [ST_W-1:0]      m_user_q;
	logic                 gcd_start_q, div_start_q;

	logic [WIDTH-1:0] an_raw, ad_raw, bn_raw, bd_raw;
	logic [WIDTH-1:0] mul_a, mul_b;
	logic [IW-1:0]    prod;
	logic [WIDTH-1:0] capped;
	logic             res_neg, too_big;
	logic [FIELD_W-1:0] n_ext;
	logic [IW-1:0]    gcd_g, div_quo, div_dividend;
	unit_sts_t        gcd_sts, div_sts;

	assign an_raw = s_tdata[0*FIELD_W +: WIDTH];
	assign ad_raw = s_tdata[1*FIELD_W +: WIDTH];
	assign bn_raw = s_tdata[2*FIELD_W +: WIDTH];
	assign bd_raw = s_tdata[3*FIELD_W +: WIDTH];

	always_comb begin
		mul_a = acc_q;
		mul_b = base_q;
		if (state_q == S_MUL) begin
			case (cmd_q)
				CMD_ADD, CMD_SUB: begin
					case (step_q)
						2'd0:    begin mul_a = an_q; mul_b = bd_q; end
						2'd1:    begin mul_a = bn_q; mul_b = ad_q; end
						default: begin mul_a = ad_q; mul_b = bd_q; end
					endcase
				end
				CMD_MUL: begin
					if (step_q == 2'd0) begin
						mul_a = an_q;
						mul_b = bn_q;
					end else begin
						mul_a = ad_q;
						mul_b = bd_q;
					end
				end
				default: begin
					if (step_q == 2'd0) begin
						mul_a = an_q;
						mul_b = bd_q;
					end else begin
						mul_a = ad_q;
						mul_b = bn_q;
					end
				end
			endcase
		end else if (pow_sq_q) begin
			mul_a = base_q;
		end
	end

	assign prod    = IW'(mul_a) * IW'(mul_b);
	assign capped  = (prod > CAP) ? CAP[WIDTH-1:0] : prod[WIDTH-1:0];
	assign res_neg = num_neg_q ^ den_neg_q;
	assign too_big = (den_q > HALF - IW'(1)) ||
		(num_q > (res_neg ? HALF : HALF - IW'(1)));
	assign n_ext   = FIELD_W'(num_q[WIDTH-1:0]);
	assign div_dividend = (state_q == S_DIVN) ? num_q : den_q;

	rau_gcd #(.IW(IW)) u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start_q),
		.x      (num_q),
		.y      (den_q),
		.g      (gcd_g),
		.sts    (gcd_sts)
	);

	rau_div #(.IW(IW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_dividend),
		.divisor  (gcd_g),
		.quo      (div_quo),
		.sts      (div_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			m_tvalid_q  <= 1'b0;
			gcd_start_q <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			gcd_start_q <= 1'b0;
			div_start_q <= 1'b0;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q    <= cmd_t'(s_tuser);
						an_neg_q <= an_raw[WIDTH-1];
						ad_neg_q <= ad_raw[WIDTH-1];
						bn_neg_q <= bn_raw[WIDTH-1];
						bd_neg_q <= bd_raw[WIDTH-1];
						an_q     <= an_raw[WIDTH-1] ? (~an_raw + WIDTH'(1)) : an_raw;
						ad_q     <= ad_raw[WIDTH-1] ? (~ad_raw + WIDTH'(1)) : ad_raw;
						bn_q     <= bn_raw[WIDTH-1] ? (~bn_raw + WIDTH'(1)) : bn_raw;
						bd_q     <= bd_raw[WIDTH-1] ? (~bd_raw + WIDTH'(1)) : bd_raw;
						e_q      <= s_tdata[4*FIELD_W +: EXP_WIDTH];
						state_q  <= S_DECODE;
					end
				end
				S_DECODE: begin
					step_q    <= 2'd0;
					num_q     <= IW'(an_q);
					den_q     <= IW'(ad_q);
					num_neg_q <= an_neg_q;
					den_neg_q <= ad_neg_q;
					state_q   <= S_FIN;
					if (ad_q == '0) begin
						res_num_q <= '0;
						res_den_q <= '0;
						res_st_q  <= ST_DIV0;
						state_q   <= S_OUT;
					end else begin
						case (cmd_q)
							CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
								if (bd_q == '0 || (cmd_q == CMD_DIV && bn_q == '0)) begin
									res_num_q <= '0;
									res_den_q <= '0;
									res_st_q  <= ST_DIV0;
									state_q   <= S_OUT;
								end else begin
									state_q   <= S_MUL;
									den_neg_q <= ad_neg_q ^ bd_neg_q;
									aux_neg_q <= bn_neg_q ^ ad_neg_q ^ (cmd_q == CMD_SUB);
									if (cmd_q == CMD_MUL) begin
										num_neg_q <= an_neg_q ^ bn_neg_q;
									end else begin
										num_neg_q <= an_neg_q ^ bd_neg_q;
									end
									if (cmd_q == CMD_DIV) begin
										den_neg_q <= ad_neg_q ^ bn_neg_q;
									end
								end
							end
							CMD_ABS: begin
								num_neg_q <= 1'b0;
								den_neg_q <= 1'b0;
							end
							CMD_POW: begin
								num_neg_q <= an_neg_q & e_q[0];
								den_neg_q <= ad_neg_q & e_q[0];
								if (e_q == '0) begin
									res_num_q <= FIELD_W'(1);
									res_den_q <= DEN_W'(1);
									res_st_q  <= ST_OK;
									state_q   <= S_OUT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_MUL: begin
					step_q <= step_q + 2'd1;
					case (step_q)
						2'd0: num_q <= prod;
						2'd1: begin
							if (cmd_q == CMD_ADD || cmd_q == CMD_SUB) begin
								aux_q <= prod;
							end else begin
								den_q   <= prod;
								state_q <= S_FIN;
							end
						end
						default: begin
							den_q   <= prod;
							state_q <= S_ADD;
						end
					endcase
				end
				S_ADD: begin
					if (num_neg_q == aux_neg_q) begin
						num_q <= num_q + aux_q;
					end else if (num_q >= aux_q) begin
						num_q <= num_q - aux_q;
					end else begin
						num_q     <= aux_q - num_q;
						num_neg_q <= aux_neg_q;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (den_q == '0) begin
						res_num_q <= '0;
						res_den_q <= '0;
						res_st_q  <= ST_DIV0;
						state_q   <= S_OUT;
					end else if (num_q == '0) begin
						res_num_q <= '0;
						res_den_q <= DEN_W'(1);
						res_st_q  <= ST_OK;
						state_q   <= S_OUT;
					end else begin
						gcd_start_q <= 1'b1;
						state_q     <= S_GCD;
					end
				end
				S_GCD: begin
					if (gcd_sts.done) begin
						div_start_q <= 1'b1;
						state_q     <= S_DIVN;
					end
				end
				S_DIVN: begin
					if (div_sts.done) begin
						num_q       <= div_quo;
						div_start_q <= 1'b1;
						state_q     <= S_DIVD;
					end
				end
				S_DIVD: begin
					if (div_sts.done) begin
						den_q <= div_quo;
						if (cmd_q == CMD_POW) begin
							acc_q     <= WIDTH'(1);
							base_q    <= num_q[WIDTH-1:0];
							ebits_q   <= e_q;
							pow_sq_q  <= 1'b0;
							pow_den_q <= 1'b0;
							state_q   <= S_POW;
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				S_POW: begin
					if (ebits_q == '0) begin
						if (!pow_den_q) begin
							num_q     <= IW'(acc_q);
							acc_q     <= WIDTH'(1);
							base_q    <= den_q[WIDTH-1:0];
							ebits_q   <= e_q;
							pow_den_q <= 1'b1;
						end else begin
							den_q   <= IW'(acc_q);
							state_q <= S_CHECK;
						end
					end else if (!pow_sq_q) begin
						if (ebits_q[0]) begin
							acc_q <= capped;
						end
						pow_sq_q <= 1'b1;
					end else begin
						base_q   <= capped;
						ebits_q  <= ebits_q >> 1;
						pow_sq_q <= 1'b0;
					end
				end
				S_CHECK: begin
					if (too_big) begin
						res_num_q <= '0;
						res_den_q <= '0;
						res_st_q  <= ST_OVF;
					end else begin
						res_num_q <= res_neg ? (~n_ext + FIELD_W'(1)) : n_ext;
						res_den_q <= DEN_W'(den_q[WIDTH-1:0]);
						res_st_q  <= ST_OK;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_data_q   <= {{PAD_W{1'b0}}, res_den_q, res_num_q};
						m_user_q   <= res_st_q;
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

`ifndef SYNTHESIS
	a_ok_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_OK) |-> (m_tdata[FIELD_W +: DEN_W] != '0))
		else $error("ok result with zero denominator");
	a_err_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
		else $error("error result with nonzero payload");
	a_gcd_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		gcd_start_q |-> !gcd_sts.busy)
		else $error("gcd started while busy");
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start_q |-> !div_sts.busy)
		else $error("divider started while busy");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("ready held after accepting a word");
`endif

endmodule
